// File: sv/haar_pkg.sv
// Package for the Haar feature unit: sequencer states, command codes and
// fixed-point helpers. No dependencies.
package haar_pkg;

	localparam int VAL_W     = 48;
	localparam int WEIGHT_W  = 16;
	localparam int FRAC_BITS = 14;

	localparam logic [1:0] CMD_WRITE_INTEGRAL = 2'd0;
	localparam logic [1:0] CMD_WRITE_RECT     = 2'd1;
	localparam logic [1:0] CMD_EVALUATE       = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TBL,
		ST_CHK,
		ST_BOX,
		ST_MUL,
		ST_ACC,
		ST_EMIT
	} state_t;

	// Saturate a wide signed value to the 48-bit result range.
	function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [65:0] v);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		hi = 66'sh7FFFFFFFFFFF;
		lo = -66'sh800000000000;
		if (v > hi) sat_val = hi[VAL_W-1:0];
		else if (v < lo) sat_val = lo[VAL_W-1:0];
		else sat_val = v[VAL_W-1:0];
	endfunction

endpackage

// File: sv/haar_feature_from_integral_image_unit.sv
// Haar feature unit top level: integral store, feature table and sequencer.
// Depends on haar_pkg.
//
// Usage. One request channel (valid/ready) carries three kinds of request:
// a write of one integral-image entry, a write of one feature rectangle slot,
// and an evaluate request with a sample corner. Writes finish in the cycle
// they are taken and produce nothing. An evaluate request produces one result
// request per feature (feature_count of them, clamped to MAX_FEATURES), in
// feature order, the final one flagged by last_feature.
// The block takes one request at a time. Evaluate walks every slot of every
// feature through the single port of the integral memory: an unused slot,
// or one with a corner outside the store, takes only the table read and the
// check; a used one goes on through four corner reads, a wait for the last
// read data, multiply and accumulate. Each feature ends with the hand-over
// of its result.
// Results sit in an output register; while the receiver stalls the sequencer
// waits at the hand-over of the next result. Reset empties the feature table
// (valid bits per slot), sets feature_count to 50 and drops any pending
// result. The integral store is not cleared: unwritten entries are undefined.
// feature_count is written through the APB port at address 0.
module haar_feature_from_integral_image_unit #(
	parameter int IMAGE_SIDE   = 128,
	parameter int MAX_FEATURES = 64,
	parameter int MAX_RECTS    = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    command,
	input  logic [7:0]                    row_index,
	input  logic [7:0]                    col_index,
	input  logic signed [haar_pkg::VAL_W-1:0] integral_value,
	input  logic [5:0]                    feature_number,
	input  logic [1:0]                    rect_slot,
	input  logic [6:0]                    rect_left,
	input  logic [6:0]                    rect_top,
	input  logic [6:0]                    rect_width,
	input  logic [6:0]                    rect_height,
	input  logic signed [haar_pkg::WEIGHT_W-1:0] rect_weight,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [5:0]                    feature_id,
	output logic signed [haar_pkg::VAL_W-1:0] feature_value,
	output logic                          range_error,
	output logic                          last_feature
);
	import haar_pkg::*;

	localparam int STORE_SIDE  = IMAGE_SIDE + 1;
	localparam int STORE_DEPTH = STORE_SIDE * STORE_SIDE;
	localparam int AW          = $clog2(STORE_DEPTH);
	localparam int SW          = $clog2(STORE_SIDE);
	localparam int SLOTS       = MAX_FEATURES * MAX_RECTS;
	localparam int TW          = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int RW          = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
	localparam int FW          = 7;

	// Memories. A table entry holds the geometry above the weight.
	logic signed [VAL_W-1:0]    store_mem [STORE_DEPTH];
	logic [27+WEIGHT_W:0]       tbl_mem   [SLOTS];
	logic [SLOTS-1:0]           slot_valid_q;

	state_t state_q, state_d;

	logic [6:0]              count_q;
	logic [FW-1:0]           count_eff;
	logic [FW-1:0]           feat_q;
	logic [RW-1:0]           slot_q;
	logic [7:0]              row_q, col_q;
	logic [SW-1:0]           y0_q, y1_q, x0_q, x1_q;
	logic signed [WEIGHT_W-1:0] w_q;
	logic [2:0]              corner_q;
	logic signed [49:0]      box_q;
	logic signed [63:0]      prod_q;
	logic signed [VAL_W-1:0] acc_q;
	logic                    err_q;

	logic signed [VAL_W-1:0]    store_rd_q;
	logic [27:0]                geo_rd_q;
	logic signed [WEIGHT_W-1:0] wgt_rd_q;
	logic                       tbl_valid_q;

	logic                    out_valid_q;
	logic [5:0]              feature_id_q;
	logic signed [VAL_W-1:0] feature_value_q;
	logic                    range_error_q;
	logic                    last_feature_q;

	logic              in_take;
	logic              cfg_write;
	logic              store_rd_en;
	logic [AW-1:0]     store_rd_addr;
	logic [TW-1:0]     tbl_addr;
	logic              out_free;
	logic              last_slot;
	logic              last_feat;

	// Table entry seen in the check state; an unwritten slot reads as unused.
	logic signed [WEIGHT_W-1:0] chk_w;
	logic [9:0]                 chk_x0, chk_x1, chk_y0, chk_y1;
	logic                       chk_out;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr == 3'd0);
	assign prdata    = (paddr == 3'd0) ? {25'd0, count_q} : 32'd0;

	assign count_eff = (count_q > 7'(MAX_FEATURES)) ? FW'(MAX_FEATURES) : count_q;
	assign in_take   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign last_slot = (slot_q == RW'(MAX_RECTS - 1));
	assign last_feat = (feat_q == count_eff - FW'(1));
	assign tbl_addr  = TW'(feat_q * MAX_RECTS) + TW'(slot_q);

	assign chk_w   = tbl_valid_q ? wgt_rd_q : '0;
	assign chk_x0  = 10'(col_q) + 10'(geo_rd_q[27:21]);
	assign chk_y0  = 10'(row_q) + 10'(geo_rd_q[20:14]);
	assign chk_x1  = chk_x0 + 10'(geo_rd_q[13:7]);
	assign chk_y1  = chk_y0 + 10'(geo_rd_q[6:0]);
	assign chk_out = (chk_x1 > 10'(IMAGE_SIDE)) || (chk_y1 > 10'(IMAGE_SIDE));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_take && command == CMD_EVALUATE && count_eff != '0) state_d = ST_TBL;
			end
			ST_TBL: state_d = ST_CHK;
			ST_CHK: begin
				if (chk_w != '0 && !chk_out) state_d = ST_BOX;
				else if (last_slot) state_d = ST_EMIT;
				else state_d = ST_TBL;
			end
			ST_BOX: begin
				if (corner_q == 3'd4) state_d = ST_MUL;
			end
			ST_MUL: state_d = ST_ACC;
			ST_ACC: state_d = last_slot ? ST_EMIT : ST_TBL;
			ST_EMIT: begin
				if (out_free) state_d = last_feat ? ST_IDLE : ST_TBL;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: handshake and store read port.
	always_comb begin
		logic [SW-1:0] ys, xs;
		in_ready    = (state_q == ST_IDLE);
		store_rd_en = (state_q == ST_BOX) && (corner_q < 3'd4);
		case (corner_q)
			3'd0:    begin ys = y0_q; xs = x0_q; end
			3'd1:    begin ys = y1_q; xs = x1_q; end
			3'd2:    begin ys = y0_q; xs = x1_q; end
			default: begin ys = y1_q; xs = x0_q; end
		endcase
		store_rd_addr = AW'(AW'(ys) * AW'(STORE_SIDE)) + AW'(xs);
	end

	// Integral store: one write or one read per cycle, registered read data.
	always_ff @(posedge clk) begin
		if (in_take && command == CMD_WRITE_INTEGRAL &&
		    9'(row_index) <= 9'(IMAGE_SIDE) && 9'(col_index) <= 9'(IMAGE_SIDE)) begin
			store_mem[AW'(AW'(row_index) * AW'(STORE_SIDE)) + AW'(col_index)] <= integral_value;
		end
		if (store_rd_en) store_rd_q <= store_mem[store_rd_addr];
	end

	logic rect_write;
	logic [TW-1:0] rect_waddr;
	assign rect_write = in_take && command == CMD_WRITE_RECT &&
	                    7'(feature_number) < 7'(MAX_FEATURES) &&
	                    4'(rect_slot) < 4'(MAX_RECTS);
	assign rect_waddr = TW'(32'(feature_number) * MAX_RECTS + 32'(rect_slot));

	// Feature table.
	always_ff @(posedge clk) begin
		if (rect_write) begin
			tbl_mem[rect_waddr] <= {rect_left, rect_top, rect_width, rect_height, rect_weight};
		end
		if (state_q == ST_TBL) begin
			{geo_rd_q, wgt_rd_q} <= tbl_mem[tbl_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			tbl_valid_q  <= 1'b0;
		end else begin
			if (rect_write) slot_valid_q[rect_waddr] <= 1'b1;
			if (state_q == ST_TBL) tbl_valid_q <= slot_valid_q[tbl_addr];
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= 7'd50;
			feat_q      <= '0;
			slot_q      <= '0;
			corner_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) count_q <= pwdata[6:0];
			// A new result replaces the one taken in the same cycle.
			if (state_q == ST_EMIT && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					feat_q <= '0;
					slot_q <= '0;
				end
				ST_CHK: begin
					corner_q <= '0;
					if (!(chk_w != '0 && !chk_out) && !last_slot) slot_q <= slot_q + RW'(1);
				end
				ST_BOX: corner_q <= corner_q + 3'd1;
				ST_ACC: begin
					if (!last_slot) slot_q <= slot_q + RW'(1);
				end
				ST_EMIT: begin
					if (out_free) begin
						feat_q      <= feat_q + FW'(1);
						slot_q      <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				row_q <= row_index;
				col_q <= col_index;
				acc_q <= '0;
				err_q <= 1'b0;
			end
			ST_CHK: begin
				w_q  <= chk_w;
				x0_q <= SW'(chk_x0);
				x1_q <= SW'(chk_x1);
				y0_q <= SW'(chk_y0);
				y1_q <= SW'(chk_y1);
				if (chk_w != '0 && chk_out) err_q <= 1'b1;
			end
			ST_BOX: begin
				// Data of the corner read issued in the previous cycle.
				if (corner_q == 3'd0) box_q <= '0;
				else if (corner_q <= 3'd2) box_q <= box_q + 50'(store_rd_q);
				else box_q <= box_q - 50'(store_rd_q);
			end
			ST_MUL: prod_q <= sat_val(66'(box_q)) * 64'(w_q);
			ST_ACC: acc_q <= sat_val(66'(acc_q) + 66'(prod_q >>> FRAC_BITS));
			ST_EMIT: begin
				if (out_free) begin
					feature_id_q    <= 6'(feat_q);
					feature_value_q <= acc_q;
					range_error_q   <= err_q;
					last_feature_q  <= last_feat;
					acc_q           <= '0;
					err_q           <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign feature_id    = feature_id_q;
	assign feature_value = feature_value_q;
	assign range_error   = range_error_q;
	assign last_feature  = last_feature_q;

endmodule

// File: dv/haar_feature_from_integral_image_unit_tb.sv
// Testbench for the Haar feature unit: random and directed requests with a
// scoreboard that predicts every feature result. Depends on haar_pkg and the
// haar_feature_from_integral_image_unit top level.
module haar_feature_from_integral_image_unit_tb;
	import haar_pkg::*;

	localparam int SIDE       = 128;
	localparam int STORE_SIDE = SIDE + 1;
	localparam int NFEAT      = 64;
	localparam int NRECT      = 4;
	// Random positions and rectangles mostly sit on a coarse grid so that few
	// store entries need writing.
	localparam int GRID       = 16;
	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam logic [2:0] REG_FEATURE_COUNT = 3'd0;
	localparam longint VMAX = 64'sh7FFFFFFFFFFF;
	localparam longint VMIN = -64'sh800000000000;

	typedef struct {
		logic [1:0]                 cmd;
		logic [7:0]                 row;
		logic [7:0]                 col;
		logic signed [VAL_W-1:0]    ival;
		logic [5:0]                 fnum;
		logic [1:0]                 slot;
		logic [6:0]                 left;
		logic [6:0]                 top;
		logic [6:0]                 width;
		logic [6:0]                 height;
		logic signed [WEIGHT_W-1:0] weight;
	} req_t;

	typedef struct {
		logic [5:0]              id;
		logic signed [VAL_W-1:0] value;
		logic                    err;
		logic                    last;
	} feat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic in_valid, in_ready;
	logic [1:0] command;
	logic [7:0] row_index, col_index;
	logic signed [VAL_W-1:0] integral_value;
	logic [5:0] feature_number;
	logic [1:0] rect_slot;
	logic [6:0] rect_left, rect_top, rect_width, rect_height;
	logic signed [WEIGHT_W-1:0] rect_weight;
	logic out_valid, out_ready;
	logic [5:0] feature_id;
	logic signed [VAL_W-1:0] feature_value;
	logic range_error, last_feature;

	haar_feature_from_integral_image_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .row_index(row_index), .col_index(col_index),
		.integral_value(integral_value), .feature_number(feature_number),
		.rect_slot(rect_slot), .rect_left(rect_left), .rect_top(rect_top),
		.rect_width(rect_width), .rect_height(rect_height), .rect_weight(rect_weight),
		.out_valid(out_valid), .out_ready(out_ready),
		.feature_id(feature_id), .feature_value(feature_value),
		.range_error(range_error), .last_feature(last_feature)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Our own copy of the block's state: integral store, feature table and
	// the feature count register.
	longint store_img [0:STORE_SIDE*STORE_SIDE-1];
	int slot_left [0:NFEAT*NRECT-1];
	int slot_top [0:NFEAT*NRECT-1];
	int slot_width [0:NFEAT*NRECT-1];
	int slot_height [0:NFEAT*NRECT-1];
	longint slot_weight [0:NFEAT*NRECT-1];
	int feature_count_q = 50;

	// State as seen when requests are queued: which store entries have a
	// write queued and which rectangle each slot will hold.
	bit gen_written [0:STORE_SIDE*STORE_SIDE-1];
	req_t gen_rect [0:NFEAT*NRECT-1];

	req_t pending_reqs[$];
	feat_t features_due[$];
	int fail_count = 0;
	// When set, both sides run without any idle cycles.
	bit calm = 1'b0;
	// Chance, in percent, that the sender drains all results before a request.
	int drain_pct = 2;

	function automatic longint sat48(longint v);
		if (v > VMAX) return VMAX;
		if (v < VMIN) return VMIN;
		return v;
	endfunction

	// Apply one accepted request to the state and queue the feature results
	// that an evaluate produces.
	function automatic void apply_request(req_t r);
		int k, n, x0, x1, y0, y1;
		longint acc, box, prod;
		bit err;
		feat_t f;
		case (r.cmd)
			CMD_WRITE_INTEGRAL: begin
				if (r.row <= SIDE && r.col <= SIDE)
					store_img[int'(r.row)*STORE_SIDE + int'(r.col)] = longint'(r.ival);
			end
			CMD_WRITE_RECT: begin
				k = int'(r.fnum)*NRECT + int'(r.slot);
				slot_left[k] = int'(r.left);
				slot_top[k] = int'(r.top);
				slot_width[k] = int'(r.width);
				slot_height[k] = int'(r.height);
				slot_weight[k] = longint'(r.weight);
			end
			CMD_EVALUATE: begin
				n = (feature_count_q > NFEAT) ? NFEAT : feature_count_q;
				for (int i = 0; i < n; i++) begin
					acc = 0;
					err = 1'b0;
					for (int s = 0; s < NRECT; s++) begin
						k = i*NRECT + s;
						if (slot_weight[k] == 0) continue;
						x0 = int'(r.col) + slot_left[k];
						x1 = x0 + slot_width[k];
						y0 = int'(r.row) + slot_top[k];
						y1 = y0 + slot_height[k];
						if (x1 > SIDE || y1 > SIDE) begin
							err = 1'b1;
							continue;
						end
						box = store_img[y0*STORE_SIDE+x0] + store_img[y1*STORE_SIDE+x1]
							- store_img[y0*STORE_SIDE+x1] - store_img[y1*STORE_SIDE+x0];
						box = sat48(box);
						prod = box * slot_weight[k];
						// Arithmetic shift floors, as the weight's fraction is dropped.
						acc = sat48(acc + (prod >>> FRAC_BITS));
					end
					f.id = i[5:0];
					f.value = acc[VAL_W-1:0];
					f.err = err;
					f.last = (i + 1 == n);
					features_due.insert(features_due.size(), f);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 20);
		return $urandom_range(50, 300);
	endfunction

	function automatic req_t noise_request();
		req_t r;
		r.cmd = 2'($urandom_range(0, 3));
		r.row = 8'($urandom);
		r.col = 8'($urandom);
		r.ival = VAL_W'({$urandom, $urandom});
		r.fnum = 6'($urandom);
		r.slot = 2'($urandom);
		r.left = 7'($urandom);
		r.top = 7'($urandom);
		r.width = 7'($urandom);
		r.height = 7'($urandom);
		r.weight = WEIGHT_W'($urandom);
		return r;
	endfunction

	function automatic req_t integral_req(int row, int col, longint v);
		req_t r;
		r = noise_request();
		r.cmd = CMD_WRITE_INTEGRAL;
		r.row = 8'(row);
		r.col = 8'(col);
		r.ival = v[VAL_W-1:0];
		return r;
	endfunction

	function automatic req_t rect_req(int f, int s, int l, int t, int w, int h, int wt);
		req_t r;
		r = noise_request();
		r.cmd = CMD_WRITE_RECT;
		r.fnum = 6'(f);
		r.slot = 2'(s);
		r.left = 7'(l);
		r.top = 7'(t);
		r.width = 7'(w);
		r.height = 7'(h);
		r.weight = WEIGHT_W'(wt);
		return r;
	endfunction

	function automatic req_t eval_req(int row, int col);
		req_t r;
		r = noise_request();
		r.cmd = CMD_EVALUATE;
		r.row = 8'(row);
		r.col = 8'(col);
		return r;
	endfunction

	// Queue one request. Ahead of an evaluate, every store entry that it will
	// read and that has no write queued yet gets a write of random data, so
	// the block never reads an entry that was never written.
	function automatic void add_request(req_t r);
		int k, n, x0, x1, y0, y1, a;
		int ys [4];
		int xs [4];
		case (r.cmd)
			CMD_WRITE_INTEGRAL: begin
				if (r.row <= SIDE && r.col <= SIDE)
					gen_written[int'(r.row)*STORE_SIDE + int'(r.col)] = 1'b1;
			end
			CMD_WRITE_RECT: begin
				gen_rect[int'(r.fnum)*NRECT + int'(r.slot)] = r;
			end
			CMD_EVALUATE: begin
				n = (feature_count_q > NFEAT) ? NFEAT : feature_count_q;
				for (int i = 0; i < n; i++) begin
					for (int s = 0; s < NRECT; s++) begin
						k = i*NRECT + s;
						if (gen_rect[k].weight == 0) continue;
						x0 = int'(r.col) + int'(gen_rect[k].left);
						x1 = x0 + int'(gen_rect[k].width);
						y0 = int'(r.row) + int'(gen_rect[k].top);
						y1 = y0 + int'(gen_rect[k].height);
						if (x1 > SIDE || y1 > SIDE) continue;
						ys = '{y0, y1, y0, y1};
						xs = '{x0, x1, x1, x0};
						for (int c = 0; c < 4; c++) begin
							a = ys[c]*STORE_SIDE + xs[c];
							if (!gen_written[a]) begin
								gen_written[a] = 1'b1;
								pending_reqs.insert(pending_reqs.size(),
									integral_req(ys[c], xs[c], longint'({$urandom, $urandom})));
							end
						end
					end
				end
			end
			default: ;
		endcase
		pending_reqs.insert(pending_reqs.size(), r);
	endfunction

	// Mostly well-formed traffic: store writes inside the image, rectangles
	// that stay small enough to land inside, and evaluates near the origin.
	function automatic req_t random_request();
		req_t r;
		int p;
		r = noise_request();
		p = $urandom_range(0, 99);
		if (p < 35) begin
			r.cmd = CMD_WRITE_INTEGRAL;
			p = $urandom_range(0, 9);
			if (p < 7) begin
				r.row = 8'(GRID * $urandom_range(0, SIDE / GRID));
				r.col = 8'(GRID * $urandom_range(0, SIDE / GRID));
			end else if (p < 9) begin
				r.row = 8'($urandom_range(0, SIDE));
				r.col = 8'($urandom_range(0, SIDE));
			end
			if ($urandom_range(0, 19) == 0)
				r.ival = $urandom_range(0, 1) ? VAL_W'(VMAX) : VAL_W'(VMIN);
		end else if (p < 65) begin
			r.cmd = CMD_WRITE_RECT;
			if ($urandom_range(0, 39) != 0) begin
				r.left = 7'(GRID * $urandom_range(0, 2));
				r.top = 7'(GRID * $urandom_range(0, 2));
				r.width = 7'(GRID * $urandom_range(0, 3));
				r.height = 7'(GRID * $urandom_range(0, 3));
			end
			p = $urandom_range(0, 99);
			if (p < 15) r.weight = '0;
			else if (p < 25) r.weight = WEIGHT_W'($urandom_range(0, 1) ? 16384 : -16384);
			else if (p < 95) r.weight = WEIGHT_W'(int'($urandom_range(0, 32768)) - 16384);
		end else if (p < 95) begin
			r.cmd = CMD_EVALUATE;
			p = $urandom_range(0, 9);
			if (p < 8) begin
				r.row = 8'(GRID * $urandom_range(0, 4));
				r.col = 8'(GRID * $urandom_range(0, 4));
			end else if (p < 9) begin
				r.row = 8'(GRID * $urandom_range(0, SIDE / GRID));
				r.col = 8'(GRID * $urandom_range(0, SIDE / GRID));
			end else begin
				// Sample corner below the image: every used slot falls outside.
				r.row = 8'($urandom_range(SIDE + 1, 255));
			end
		end else begin
			r.cmd = CMD_NONE;
		end
		return r;
	endfunction

	// Request driver: takes requests from pending_reqs, predicts each one on
	// acceptance and inserts random gaps between them.
	int in_gap = 0;
	bit drain_first = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		req_t r;
		logic next_valid;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			next_valid = in_valid;
			if (in_valid && in_ready) begin
				apply_request('{command, row_index, col_index, integral_value,
					feature_number, rect_slot, rect_left, rect_top, rect_width,
					rect_height, rect_weight});
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (drain_first && features_due.size() != 0) begin
					// Hold off until the block has handed over every result.
				end else if (pending_reqs.size() != 0) begin
					r = pending_reqs.pop_front();
					command <= r.cmd;
					row_index <= r.row;
					col_index <= r.col;
					integral_value <= r.ival;
					feature_number <= r.fnum;
					rect_slot <= r.slot;
					rect_left <= r.left;
					rect_top <= r.top;
					rect_width <= r.width;
					rect_height <= r.height;
					rect_weight <= r.weight;
					next_valid = 1'b1;
					in_gap = pick_gap();
					drain_first = !calm && ($urandom_range(0, 99) < drain_pct);
				end
			end
			in_valid <= next_valid;
		end
	end

	// Result monitor: random back-pressure, and each accepted result is
	// compared field by field with the oldest prediction.
	int out_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		feat_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (features_due.size() == 0) begin
					$error("unexpected result: feature_id %0d value %0d",
						feature_id, feature_value);
					fail_count++;
				end else begin
					e = features_due.pop_front();
					if (feature_id !== e.id) begin
						$error("feature_id: expected %0d, got %0d", e.id, feature_id);
						fail_count++;
					end
					if (feature_value !== e.value) begin
						$error("feature_value: expected %0d, got %0d", e.value, feature_value);
						fail_count++;
					end
					if (range_error !== e.err) begin
						$error("range_error: expected %0d, got %0d", e.err, range_error);
						fail_count++;
					end
					if (last_feature !== e.last) begin
						$error("last_feature: expected %0d, got %0d", e.last, last_feature);
						fail_count++;
					end
				end
			end
			if (calm) begin
				out_ready <= 1'b1;
			end else if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) out_gap = pick_gap();
			end
		end
	end

	// Sampled between edges so that the driver and monitor have settled. Once
	// every request is taken and every result handed over, the block is idle.
	task automatic wait_idle();
		while (pending_reqs.size() != 0 || in_valid || features_due.size() != 0)
			@(negedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_feature_count(int v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_FEATURE_COUNT;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		feature_count_q = v & 32'h7f;
	endtask

	initial begin
		int counts [6] = '{1, 127, 0, 64, 17, 33};
		req_t r;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		command = '0;
		row_index = '0;
		col_index = '0;
		integral_value = '0;
		feature_number = '0;
		rect_slot = '0;
		rect_left = '0;
		rect_top = '0;
		rect_width = '0;
		rect_height = '0;
		rect_weight = '0;
		foreach (slot_weight[k]) begin
			slot_left[k] = 0;
			slot_top[k] = 0;
			slot_width[k] = 0;
			slot_height[k] = 0;
			slot_weight[k] = 0;
			gen_rect[k] = '{default: '0};
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset feature count. Corners at the extremes
		// make the box sum saturate; two full-image slots then saturate the sum.
		add_request(integral_req(0, 0, VMIN));
		add_request(integral_req(SIDE, SIDE, VMAX));
		add_request(integral_req(0, SIDE, VMIN));
		add_request(integral_req(SIDE, 0, VMIN));
		add_request(integral_req(200, 255, 0));
		add_request(rect_req(0, 0, 0, 0, SIDE, SIDE, 16384));
		add_request(rect_req(0, 3, 0, 0, SIDE, SIDE, 16384));
		add_request(rect_req(1, 0, 0, 0, SIDE, SIDE, -16384));
		add_request(rect_req(1, 1, 0, 0, SIDE, SIDE, -16384));
		add_request(rect_req(2, 0, 127, 127, 127, 127, 100));
		add_request(rect_req(2, 1, 3, 4, 5, 6, -1));
		add_request(rect_req(3, 2, 1, 1, 0, 0, 0));
		add_request(rect_req(49, 1, 10, 10, 20, 20, -32768));
		add_request(rect_req(63, 3, 2, 2, 7, 7, 16383));
		add_request(eval_req(0, 0));
		add_request(eval_req(5, 9));
		add_request(eval_req(SIDE, SIDE));
		add_request(eval_req(255, 255));
		r = noise_request();
		r.cmd = CMD_NONE;
		add_request(r);
		wait_idle();
		write_feature_count(64);
		add_request(eval_req(0, 0));
		add_request(eval_req(1, 2));
		wait_idle();

		// Random phases, each at its own feature count.
		foreach (counts[p]) begin
			write_feature_count(counts[p]);
			calm = (p == 4);
			drain_pct = (p == 1) ? 10 : 2;
			for (int i = 0; i < 70; i++) add_request(random_request());
			wait_idle();
		end
		calm = 1'b0;

		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#(8 * 50000000);
		$display("== FAIL ==");
		$finish;
	end

endmodule

// File: sim.f
sv/haar_pkg.sv
sv/haar_feature_from_integral_image_unit.sv
dv/haar_feature_from_integral_image_unit_tb.sv
